// ===== rtl/core/usbtd_pkg.sv =====
// Package with the microcode format, program table and descriptor constants.
package usbtd_pkg;

  localparam logic [7:0]  PID_SETUP   = 8'h2D;
  localparam logic [7:0]  PID_IN      = 8'h69;
  localparam logic [7:0]  PID_OUT     = 8'hE1;
  localparam logic [10:0] MAXLEN_ZERO = 11'h7FF;
  localparam logic [10:0] MAXLEN_SETUP = 11'd7;
  localparam logic [31:0] STS_CERR3   = 32'(3) << 27;
  localparam logic [31:0] STS_ACTIVE  = 32'(1) << 23;
  localparam logic [31:0] STS_LOWSPD  = 32'(1) << 26;
  localparam logic [31:0] STS_IOC     = 32'(1) << 24;
  localparam logic [31:0] LNK_DEPTH   = 32'(1) << 2;
  localparam logic [31:0] LNK_TERM    = 32'(1) << 0;
  localparam logic [6:0]  LIMIT_DEFAULT = 7'd8;
  localparam int unsigned MAX_CHAIN   = 16;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_ACCEPT,
    ACT_SETUP,
    ACT_DATA,
    ACT_STATUS,
    ACT_REJECT
  } act_e;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_ALWAYS,
    JMP_NO_ITEM,
    JMP_REJECT,
    JMP_NO_DATA,
    JMP_MORE
  } jmp_e;

  typedef logic [2:0] upc_t;

  localparam upc_t UPC_WAIT   = 3'd0;
  localparam upc_t UPC_CHECK  = 3'd1;
  localparam upc_t UPC_SETUP  = 3'd2;
  localparam upc_t UPC_DATA   = 3'd3;
  localparam upc_t UPC_STATUS = 3'd4;
  localparam upc_t UPC_REJECT = 3'd5;

  typedef struct packed {
    act_e act;
    jmp_e jmp;
    upc_t target;
  } uword_t;

  typedef struct packed {
    logic item;
    logic reject;
    logic no_data;
    logic more;
    logic hold;
  } useq_flags_t;

  function automatic uword_t ucode_rom(upc_t pc);
    uword_t w;
    unique case (pc)
      UPC_WAIT:   w = '{act: ACT_ACCEPT, jmp: JMP_NO_ITEM, target: UPC_WAIT};
      UPC_CHECK:  w = '{act: ACT_NONE,   jmp: JMP_REJECT,  target: UPC_REJECT};
      UPC_SETUP:  w = '{act: ACT_SETUP,  jmp: JMP_NO_DATA, target: UPC_STATUS};
      UPC_DATA:   w = '{act: ACT_DATA,   jmp: JMP_MORE,    target: UPC_DATA};
      UPC_STATUS: w = '{act: ACT_STATUS, jmp: JMP_ALWAYS,  target: UPC_WAIT};
      UPC_REJECT: w = '{act: ACT_REJECT, jmp: JMP_ALWAYS,  target: UPC_WAIT};
      default:    w = '{act: ACT_NONE,   jmp: JMP_ALWAYS,  target: UPC_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/usbtd_sequencer.sv =====
// Microcode step counter with program table lookup and conditional jumps.
module usbtd_sequencer
  import usbtd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  useq_flags_t flags_i,
  output uword_t      uword_o
);

  upc_t   pc_q, pc_d;
  uword_t uword;
  logic   take;

  assign uword   = ucode_rom(pc_q);
  assign uword_o = uword;

  always_comb begin
    unique case (uword.jmp)
      JMP_NEXT:    take = 1'b0;
      JMP_ALWAYS:  take = 1'b1;
      JMP_NO_ITEM: take = !flags_i.item;
      JMP_REJECT:  take = flags_i.reject;
      JMP_NO_DATA: take = flags_i.no_data;
      JMP_MORE:    take = flags_i.more;
      default:     take = 1'b1;
    endcase
    if (flags_i.hold) begin
      pc_d = pc_q;
    end else if (take) begin
      pc_d = uword.target;
    end else begin
      pc_d = pc_q + upc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= UPC_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== rtl/core/usb_control_td_chain_builder.sv =====
// Top level of the USB control-transfer descriptor chain builder.
// One request transfer yields a chain of descriptor transfers: SETUP, data descriptors, STATUS,
// or a single rejected transfer. A small microprogram walks the chain. The request is accepted in
// the WAIT step and checked in the CHECK step, then one descriptor is emitted per cycle while the
// output is not stalled.
// The next request is accepted once the previous chain has been handed to the output register.
module usb_control_td_chain_builder
  import usbtd_pkg::*;
#(
  parameter int unsigned POOL_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [6:0]  device_address_i,
  input  logic        low_speed_i,
  input  logic [6:0]  packet_limit_i,
  input  logic [31:0] setup_address_i,
  input  logic [31:0] data_address_i,
  input  logic [15:0] data_length_i,
  input  logic        data_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  descriptor_index_o,
  output logic [31:0] link_word_o,
  output logic [31:0] status_word_o,
  output logic [31:0] token_word_o,
  output logic [31:0] buffer_word_o,
  output logic        last_descriptor_o,
  output logic        rejected_o
);

  localparam int unsigned ChainMax = (POOL_DEPTH < MAX_CHAIN) ? POOL_DEPTH : MAX_CHAIN;
  localparam logic [3:0] MaxData = 4'(ChainMax - 2);

  logic [31:0] pool_base_q;
  logic        present_q;

  logic [6:0]  addr_q;
  logic        low_q;
  logic [6:0]  lim_q;
  logic [31:0] setup_q;
  logic        din_q;
  logic [15:0] len_q;
  logic [15:0] bytes_left_q;
  logic        toggle_q;
  logic [31:0] ptr_q;
  logic [3:0]  slot_q;

  logic        out_valid_q;
  logic [3:0]  index_q;
  logic [31:0] link_q, status_q, token_q, buffer_q;
  logic        last_q, rejected_q;

  uword_t      uword;
  useq_flags_t flags;
  logic        in_xfer, emit_act, emit, more;
  logic [10:0] data_cap;
  logic [6:0]  chunk;
  logic [10:0] maxlen;
  logic        tog;
  logic [7:0]  pid;
  logic [31:0] next_addr;
  logic [31:0] sts;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {31'b0, present_q} : pool_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q <= '0;
      present_q   <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        present_q <= pwdata[0];
      end else begin
        pool_base_q <= pwdata;
      end
    end
  end

  usbtd_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .uword_o (uword)
  );

  assign in_stall_o = (uword.act != ACT_ACCEPT);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign emit_act   = (uword.act == ACT_SETUP) || (uword.act == ACT_DATA) ||
                      (uword.act == ACT_STATUS) || (uword.act == ACT_REJECT);
  assign emit       = emit_act && !(out_valid_q && out_stall_i);
  assign data_cap   = {7'b0, MaxData} * {4'b0, lim_q};
  assign more       = bytes_left_q > {9'b0, lim_q};

  assign flags.item    = in_xfer;
  assign flags.reject  = !present_q || (len_q > {5'b0, data_cap});
  assign flags.no_data = (len_q == '0);
  assign flags.more    = more;
  assign flags.hold    = emit_act && !emit;

  assign chunk     = more ? lim_q : bytes_left_q[6:0];
  assign next_addr = pool_base_q + ({27'b0, 5'(slot_q) + 5'd1} << 5);

  always_comb begin
    sts = STS_ACTIVE | STS_CERR3;
    if (low_q) begin
      sts = sts | STS_LOWSPD;
    end
    unique case (uword.act)
      ACT_SETUP: begin
        maxlen = MAXLEN_SETUP;
        tog    = 1'b0;
        pid    = PID_SETUP;
      end
      ACT_DATA: begin
        maxlen = {4'b0, chunk - 7'd1};
        tog    = toggle_q;
        pid    = din_q ? PID_IN : PID_OUT;
      end
      default: begin
        maxlen = MAXLEN_ZERO;
        tog    = 1'b1;
        pid    = din_q ? PID_OUT : PID_IN;
        sts    = sts | STS_IOC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= '0;
      toggle_q     <= 1'b1;
      ptr_q        <= '0;
      slot_q       <= '0;
    end else if (in_xfer) begin
      bytes_left_q <= data_length_i;
      toggle_q     <= 1'b1;
      ptr_q        <= data_address_i;
      slot_q       <= '0;
    end else if (emit) begin
      slot_q <= slot_q + 4'd1;
      if (uword.act == ACT_DATA) begin
        bytes_left_q <= bytes_left_q - {9'b0, chunk};
        toggle_q     <= !toggle_q;
        ptr_q        <= ptr_q + {25'b0, chunk};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      addr_q  <= device_address_i;
      low_q   <= low_speed_i;
      lim_q   <= (packet_limit_i == '0) ? LIMIT_DEFAULT : packet_limit_i;
      setup_q <= setup_address_i;
      din_q   <= data_in_i;
      len_q   <= data_length_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (uword.act == ACT_REJECT) begin
        index_q    <= '0;
        link_q     <= '0;
        status_q   <= '0;
        token_q    <= '0;
        buffer_q   <= '0;
        last_q     <= 1'b0;
        rejected_q <= 1'b1;
      end else begin
        index_q    <= slot_q;
        link_q     <= (uword.act == ACT_STATUS) ? LNK_TERM : (next_addr | LNK_DEPTH);
        status_q   <= sts;
        token_q    <= {maxlen, 1'b0, tog, 4'b0, addr_q, pid};
        buffer_q   <= (uword.act == ACT_SETUP) ? setup_q :
                      (uword.act == ACT_DATA) ? ptr_q : 32'b0;
        last_q     <= (uword.act == ACT_STATUS);
        rejected_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign descriptor_index_o = index_q;
  assign link_word_o        = link_q;
  assign status_word_o      = status_q;
  assign token_word_o       = token_q;
  assign buffer_word_o      = buffer_q;
  assign last_descriptor_o  = last_q;
  assign rejected_o         = rejected_q;

endmodule
